### rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants for the pressure compensation block
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned NumCfg = 6;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [2:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } t_state;

    // reading kind on the input, result kind on the output
    localparam logic OpTemp  = 1'b0;
    localparam logic OpPress = 1'b1;

    localparam logic [31:0] Const4000 = 32'd4000;
    localparam logic [31:0] Const0x8000 = 32'h8000;
    localparam logic [31:0] ConstC350 = 32'hC350;
    localparam logic [31:0] ConstBDE = 32'hBDE;
    localparam logic [31:0] ConstM1CBD = 32'hFFFF_E343;
    localparam logic [31:0] ConstECF = 32'hECF;

    function automatic logic [31:0] sx16(input logic [15:0] h);
        sx16 = {{16{h[15]}}, h};
    endfunction

    // signed truncating divide by a power of two
    function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input logic [4:0] sh);
        logic [31:0] m;
        logic [31:0] q;
        m = a[31] ? (32'd0 - a) : a;
        q = m >> sh;
        sdiv_p2 = a[31] ? (32'd0 - q) : q;
    endfunction

endpackage

### rtl/core/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// integer temperature and pressure compensation with one shared multiplier
// and one shared restoring divider, driven by a small step sequencer
// ----------------------------------------------------------------------------
// Usage: write the calibration registers through i_cfg_we/i_cfg_idx/i_cfg_data
// while the block is idle. Raw items enter on i_valid / o_stall; one result
// leaves per item on o_valid / i_stall. i_stall holds the result register.
// A temperature result takes two multiplies and one 32-step signed divide;
// a pressure result takes ten multiplies and one 32-step unsigned divide.
// The divider loop forms one quotient bit per cycle. A zero divisor ends
// the item early, before the divide.
// Items are taken one at a time: o_stall is high from the transfer of an
// item until its result transfers out, and the next item can transfer in
// the cycle after that. A stalled receiver stalls the input for as long.
// Reset clears coefficients, B5 and the sequencer, and sets oversampling to 3.
// A zero divisor gives value 0 with o_div_error set; a failed temperature
// item leaves the stored B5 unchanged.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bpc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [23:0]                 i_raw_reading,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_kind,
    output logic signed [31:0]          o_value,
    output logic                        o_div_error
);
    import bpc_pkg::*;

    logic [31:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [1:0]  r_oss;
    logic [31:0] r_b5;
    t_state      r_state, n_state;
    logic [4:0]  r_step, n_step;
    logic        r_op;
    logic [23:0] r_raw;
    // working registers
    logic [31:0] r_a, r_b, r_x1, r_sq, r_b6, r_b3, r_p, r_t, n_a, n_b;
    logic [31:0] n_x1, n_sq, n_b6, n_b3, n_p, n_t, r_m, n_m;
    // divider
    logic [31:0] r_dq, r_dr, r_dd, n_dq, n_dr, n_dd;
    logic [5:0]  r_dc, n_dc;
    logic        r_dneg, n_dneg;
    logic        r_ov, n_ov;
    logic [31:0] r_val, n_val;
    logic        r_err, n_err, r_okb5, n_okb5;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, up;
    logic [32:0] dtrial;
    logic [31:0] dshift, dq_fix;

    assign ac1 = sx16(r_c0[31:16]);
    assign ac2 = sx16(r_c0[15:0]);
    assign ac3 = sx16(r_c1[31:16]);
    assign ac4 = {16'd0, r_c1[15:0]};
    assign ac5 = {16'd0, r_c2[31:16]};
    assign ac6 = {16'd0, r_c2[15:0]};
    assign b1  = sx16(r_c3[31:16]);
    assign b2  = sx16(r_c3[15:0]);
    assign mc  = sx16(r_c4[31:16]);
    assign md  = sx16(r_c4[15:0]);
    assign up  = {8'd0, r_raw} >> (4'd8 - {2'd0, r_oss});

    // restoring divider step on magnitudes
    assign dshift = {r_dr[30:0], r_dq[31]};
    assign dtrial = {r_dr, r_dq[31]} - {1'b0, r_dd};
    assign dq_fix = r_dneg ? (32'd0 - r_dq) : r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0;
            r_oss <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AC1_AC2: r_c0 <= i_cfg_data;
                CFG_AC3_AC4: r_c1 <= i_cfg_data;
                CFG_AC5_AC6: r_c2 <= i_cfg_data;
                CFG_B1_B2:   r_c3 <= i_cfg_data;
                CFG_MC_MD:   r_c4 <= i_cfg_data;
                CFG_OSS:     r_oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_b5    <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            // b5 is latched once, on the first cycle in the output state
            if (r_state == ST_OUT && r_okb5 && !r_ov) r_b5 <= r_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_op  <= i_op;
            r_raw <= i_raw_reading;
        end
        r_a <= n_a; r_b <= n_b; r_m <= n_m;
        r_x1 <= n_x1; r_sq <= n_sq; r_b6 <= n_b6;
        r_b3 <= n_b3; r_p <= n_p; r_t <= n_t;
        r_dq <= n_dq; r_dr <= n_dr; r_dd <= n_dd; r_dc <= n_dc; r_dneg <= n_dneg;
        r_ov <= n_ov; r_val <= n_val; r_err <= n_err; r_okb5 <= n_okb5;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_kind      = r_op;
    assign o_value     = r_val;
    assign o_div_error = r_err;

    // sequencer: most steps load r_a, r_b, some load the divider; ST_MUL forms r_m = r_a * r_b;
    // ST_NEXT consumes the product (or quotient) and sets up the next step
    always_comb begin
        logic [31:0] prod;
        n_state = r_state; n_step = r_step;
        n_a = r_a; n_b = r_b; n_m = r_m;
        n_x1 = r_x1; n_sq = r_sq; n_b6 = r_b6; n_b3 = r_b3;
        n_p = r_p; n_t = r_t;
        n_dq = r_dq; n_dr = r_dr; n_dd = r_dd; n_dc = r_dc; n_dneg = r_dneg;
        n_ov = r_ov; n_val = r_val; n_err = r_err; n_okb5 = r_okb5;
        prod = r_a * r_b;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                n_ov = 1'b0;
                if (i_valid) begin
                    n_okb5 = 1'b0;
                    n_err = 1'b0;
                    if (i_op == OpPress) begin
                        n_a = r_b5 - Const4000;
                        n_b = r_b5 - Const4000;
                        n_b6 = r_b5 - Const4000;
                    end else begin
                        n_a = {16'd0, i_raw_reading[15:0]} - ac6;
                        n_b = ac5;
                    end
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_m = prod;
                n_state = ST_NEXT;
            end
            ST_DIV: begin
                if (dtrial[32]) begin
                    n_dr = dshift;
                    n_dq = {r_dq[30:0], 1'b0};
                end else begin
                    n_dr = dtrial[31:0];
                    n_dq = {r_dq[30:0], 1'b1};
                end
                n_dc = r_dc - 6'd1;
                if (r_dc == 6'd1) n_state = ST_NEXT;
            end
            ST_NEXT: begin
                n_step = r_step + 5'd1;
                n_state = ST_MUL;
                if (r_op == OpTemp) begin
                    unique case (r_step)
                        5'd0: begin
                            n_x1 = sdiv_p2(r_m, 5'd15);
                            n_a = mc; n_b = 32'h800;
                        end
                        5'd1: begin
                            if (r_x1 + md == 32'd0) begin
                                n_err = 1'b1; n_val = '0; n_state = ST_OUT;
                            end else begin
                                n_dneg = r_m[31] ^ ((r_x1 + md) >> 31 != 0);
                                n_dq = r_m[31] ? 32'd0 - r_m : r_m;
                                n_dd = (r_x1 + md) >> 31 != 0 ? 32'd0 - (r_x1 + md)
                                                              : r_x1 + md;
                                n_dr = '0; n_dc = 6'd32; n_state = ST_DIV;
                            end
                        end
                        default: begin
                            n_x1 = r_x1 + dq_fix;
                            n_val = sdiv_p2(r_x1 + dq_fix + 32'd8, 5'd4);
                            n_okb5 = 1'b1;
                            n_state = ST_OUT;
                        end
                    endcase
                end else begin
                    unique case (r_step)
                        5'd0: begin
                            n_sq = sdiv_p2(r_m, 5'd12);
                            n_a = b2; n_b = sdiv_p2(r_m, 5'd12);
                        end
                        5'd1: begin
                            n_x1 = sdiv_p2(r_m, 5'd11);
                            n_a = ac2; n_b = r_b6;
                        end
                        5'd2: begin
                            n_b3 = sdiv_p2((((ac1 << 2) + r_x1 + sdiv_p2(r_m, 5'd11))
                                            << r_oss) + 32'd2, 5'd2);
                            n_a = ac3; n_b = r_b6;
                        end
                        5'd3: begin
                            n_x1 = sdiv_p2(r_m, 5'd13);
                            n_a = b1; n_b = r_sq;
                        end
                        5'd4: begin
                            n_a = ac4;
                            n_b = sdiv_p2(r_x1 + sdiv_p2(r_m, 5'd16) + 32'd2, 5'd2)
                                  + Const0x8000;
                        end
                        5'd5: begin
                            n_t = r_m >> 15;
                            if ((r_m >> 15) == 32'd0) begin
                                n_err = 1'b1; n_val = '0; n_state = ST_OUT;
                            end else begin
                                n_a = up - r_b3; n_b = ConstC350 >> r_oss;
                            end
                        end
                        5'd6: begin
                            // r_m holds b7
                            n_dneg = r_m[31];
                            n_dq = r_m[31] ? r_m : (r_m << 1);
                            n_dd = r_t; n_dr = '0; n_dc = 6'd32; n_state = ST_DIV;
                        end
                        5'd7: begin
                            n_p = r_dneg ? (r_dq << 1) : r_dq;
                            n_a = sdiv_p2(r_dneg ? (r_dq << 1) : r_dq, 5'd8);
                            n_b = sdiv_p2(r_dneg ? (r_dq << 1) : r_dq, 5'd8);
                        end
                        5'd8: begin
                            n_a = r_m; n_b = ConstBDE;
                        end
                        5'd9: begin
                            n_x1 = sdiv_p2(r_m, 5'd16);
                            n_a = ConstM1CBD; n_b = r_p;
                        end
                        default: begin
                            n_val = r_p + sdiv_p2(r_x1 + sdiv_p2(r_m, 5'd16) + ConstECF,
                                                  5'd4);
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                n_ov = 1'b1;
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### dv/tb_barometric_pressure_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation
// self-checking bench: a directed table, then random temperature and pressure
// readings across several coefficient sets, each result checked in order
// against a behavioral model of the compensation math
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation;
    import bpc_pkg::*;

    localparam int unsigned IdleLimit = 20000;
    localparam int unsigned NumRandom = 1700;

    typedef struct {
        logic        op;
        logic [23:0] raw;
        logic        chk;
        logic [31:0] value;
        logic        div_error;
    } t_row;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        div_error;
        logic        chk;
        logic [31:0] dvalue;
        logic        derr;
    } t_exp;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [23:0] raw;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic signed [31:0] value;
    logic        div_error;

    // model state
    logic [31:0] m_ac12, m_ac34, m_ac56, m_b12, m_mcmd, m_b5;
    logic [1:0]  m_oss;

    t_exp        comp_q[$];
    int          errors;
    int unsigned idle_cycles;
    bit          no_idle;

    barometric_pressure_compensation u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_op          (op),
        .i_raw_reading (raw),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_kind        (kind),
        .o_value       (value),
        .o_div_error   (div_error)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] ext16(logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic logic [31:0] idiv(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // compensation of one reading; updates stored b5 on a good temperature
    task automatic compensate(input logic o, input logic [23:0] r,
                              output logic [31:0] v, output logic err);
        logic [31:0] ut, x1, x2, x3, den, b5, up, ac1, ac2, ac3, ac4, b1, b2;
        logic [31:0] b6, sq, b3, b4, b7, p, q;
        logic [1:0]  s;
        v = 32'd0;
        err = 1'b0;
        if (o == OpTemp) begin
            ut = {16'd0, r[15:0]};
            x1 = idiv((ut - {16'd0, m_ac56[15:0]}) * {16'd0, m_ac56[31:16]}, 32'h8000);
            den = x1 + ext16(m_mcmd[15:0]);
            if (den == 0) begin
                err = 1'b1;
            end else begin
                x2 = idiv(ext16(m_mcmd[31:16]) * 32'h800, den);
                b5 = x1 + x2;
                m_b5 = b5;
                v = idiv(b5 + 8, 32'h10);
            end
        end else begin
            s = m_oss;
            up = {8'd0, r} >> (8 - s);
            ac1 = ext16(m_ac12[31:16]);
            ac2 = ext16(m_ac12[15:0]);
            ac3 = ext16(m_ac34[31:16]);
            ac4 = {16'd0, m_ac34[15:0]};
            b1 = ext16(m_b12[31:16]);
            b2 = ext16(m_b12[15:0]);
            b6 = m_b5 - 4000;
            sq = idiv(b6 * b6, 32'h1000);
            x1 = idiv(b2 * sq, 32'h800);
            x2 = idiv(ac2 * b6, 32'h800);
            x3 = x1 + x2;
            b3 = idiv(((ac1 * 4 + x3) << s) + 2, 4);
            x1 = idiv(ac3 * b6, 32'h2000);
            x2 = idiv(b1 * sq, 32'h10000);
            x3 = idiv(x1 + x2 + 2, 4);
            b4 = (ac4 * (x3 + 32'h8000)) / 32'h8000;
            if (b4 == 0) begin
                err = 1'b1;
            end else begin
                b7 = (up - b3) * (32'hC350 >> s);
                if (b7 < 32'h8000_0000) p = (b7 * 2) / b4;
                else p = (b7 / b4) * 2;
                q = idiv(p, 32'h100);
                x1 = idiv((q * q) * 32'hBDE, 32'h10000);
                x2 = idiv(32'hFFFF_E343 * p, 32'h10000);
                v = p + idiv(x1 + x2 + 32'hECF, 32'h10);
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_AC1_AC2: m_ac12 = d;
            CFG_AC3_AC4: m_ac34 = d;
            CFG_AC5_AC6: m_ac56 = d;
            CFG_B1_B2:   m_b12 = d;
            CFG_MC_MD:   m_mcmd = d;
            default:     m_oss = d[1:0];
        endcase
    endtask

    // called at a falling edge, right after the last send
    task automatic drain();
        in_valid <= 1'b0;
        while (comp_q.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // drive one reading, called at a falling edge, returns at the falling edge
    // after its transfer with valid still high; drain drops it
    task automatic send(input logic o, input logic [23:0] r, input logic c,
                        input logic [31:0] dv, input logic de);
        t_exp e;
        if (!no_idle && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < 32);
        end
        in_valid <= 1'b1;
        op <= o;
        raw <= r;
        e.kind = o;
        compensate(o, r, e.value, e.div_error);
        e.chk = c;
        e.dvalue = dv;
        e.derr = de;
        do @(posedge clk); while (in_stall);
        comp_q.push_back(e);
        @(negedge clk);
    endtask

    task automatic load_set(input logic [31:0] a, b, c, d, e, input logic [1:0] s);
        write_reg(CFG_AC1_AC2, a);
        write_reg(CFG_AC3_AC4, b);
        write_reg(CFG_AC5_AC6, c);
        write_reg(CFG_B1_B2, d);
        write_reg(CFG_MC_MD, e);
        write_reg(CFG_OSS, {30'd0, s});
    endtask

    // output side: random stall, check at rising edge
    always @(negedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= !no_idle && ($urandom_range(99) < 32);
    end

    always @(posedge clk) begin
        t_exp e;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall) begin
                if (comp_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    e = comp_q.pop_front();
                    if (e.chk && (e.dvalue != e.value || e.derr != e.div_error)) begin
                        $error("table row disagrees with model: value %0h/%0h", e.dvalue,
                               e.value);
                        errors++;
                    end
                    if (kind !== e.kind) begin
                        $error("kind expected %0d actual %0d", e.kind, kind);
                        errors++;
                    end
                    if (value !== e.value) begin
                        $error("value expected %0d actual %0d", $signed(e.value), value);
                        errors++;
                    end
                    if (div_error !== e.div_error) begin
                        $error("div_error expected %0d actual %0d", e.div_error, div_error);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IdleLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    t_row tbl[$];
    int   k;
    logic [31:0] rv;

    initial begin
        errors = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = 1'b0;
        raw = '0;
        out_stall = 1'b0;
        m_ac12 = 0; m_ac34 = 0; m_ac56 = 0; m_b12 = 0; m_mcmd = 0; m_b5 = 0;
        m_oss = 2'd3;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // after reset: md=0 so temperature divisor zero, ac4=0 so pressure too
        tbl.push_back('{OpPress, 24'hFFFFFF, 1'b1, 32'd0, 1'b1});
        tbl.push_back('{OpTemp, 24'h000000, 1'b1, 32'd0, 1'b1});
        tbl.push_back('{OpTemp, 24'hFFFFFF, 1'b1, 32'd0, 1'b1});
        foreach (tbl[i]) send(tbl[i].op, tbl[i].raw, tbl[i].chk, tbl[i].value,
                              tbl[i].div_error);
        drain();

        // typical datasheet coefficients
        load_set({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                 {16'd32757, 16'd23153}, {16'd6190, 16'd4}, {-16'sd8711, 16'd2868},
                 2'd0);
        tbl.delete();
        tbl.push_back('{OpPress, 24'h5D23FF, 1'b0, 0, 0}); // pressure before temperature
        tbl.push_back('{OpTemp, 24'hFF6C0B, 1'b0, 0, 0}); // upper bits ignored
        tbl.push_back('{OpPress, 24'h5D23FF, 1'b0, 0, 0});
        tbl.push_back('{OpTemp, 24'h00FFFF, 1'b0, 0, 0});
        tbl.push_back('{OpPress, 24'h000000, 1'b0, 0, 0});
        tbl.push_back('{OpPress, 24'hFFFFFF, 1'b0, 0, 0});
        foreach (tbl[i]) send(tbl[i].op, tbl[i].raw, 1'b0, 0, 0);
        drain();

        // extreme coefficients, oversampling 3
        load_set(32'h8000_7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_8000,
                 32'h7FFF_8000, 2'd3);
        for (int i = 0; i < 8; i++) begin
            rv = $urandom();
            send(i[0], rv[23:0], 1'b0, 0, 0);
        end
        drain();

        // hold off until all results are in, then random phases
        for (int ph = 0; ph < 6; ph++) begin
            no_idle = (ph == 2);
            if (ph == 0 || ph == 4) begin
                load_set({16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                         {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                         {-16'sd8711, 16'd2868}, ph[1:0]);
            end else begin
                load_set($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         2'($urandom_range(3)));
            end
            for (int i = 0; i < NumRandom / 6; i++) begin
                k = $urandom_range(99);
                rv = $urandom();
                if (k < 40) send(OpTemp, (ph == 0 || ph == 4) ? {rv[23:16], 16'd27898 +
                                 {4'd0, rv[11:0]}} : rv[23:0], 1'b0, 0, 0);
                else send(OpPress, rv[23:0], 1'b0, 0, 0);
            end
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

### barometric_pressure_compensation.f
rtl/core/bpc_pkg.sv
rtl/core/barometric_pressure_compensation.sv
dv/tb_barometric_pressure_compensation.sv
